>>> rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants of the monochromatic clique counter.
// ----------------------------------------------------------------------------
package mcc_pkg;

	localparam int ENERGY_W = 34;
	localparam int VC_W     = 7;
	localparam int SIZE_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_SIZE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_SIZE    = 2'd2;

	typedef enum logic [7:0] {
		ST_LOAD  = 8'b0000_0001,
		ST_INIT  = 8'b0000_0010,
		ST_RD    = 8'b0000_0100,
		ST_CMP   = 8'b0000_1000,
		ST_COUNT = 8'b0001_0000,
		ST_ADV   = 8'b0010_0000,
		ST_NEXT  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic load;   // store one accepted edge
		logic init;   // first subset of the current pass
		logic rd;     // read the edge of the current pair
		logic step;   // move to the next pair
		logic inc;    // count the current subset
		logic adv;    // next subset in lexicographic order
		logic emit;   // load the result register
		logic pass;   // 0: red pass, 1: blue pass
	} cmd_t;

	typedef struct packed {
		logic load_last;
		logic skip;
		logic single;
		logic mismatch;
		logic pair_last;
		logic subset_last;
		logic out_busy;
	} status_t;

endpackage

>>> rtl/mcc_ctrl.sv
// ----------------------------------------------------------------------------
// mcc_ctrl
// Sequencer for loading, subset enumeration and result hand-off.
// ----------------------------------------------------------------------------
module mcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  mcc_pkg::status_t  sts,
	output logic              in_ready,
	output mcc_pkg::cmd_t     cmd
);

	mcc_pkg::state_t state_q, state_d;
	logic            pass_q, pass_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcc_pkg::ST_LOAD;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		cmd      = '0;
		cmd.pass = pass_q;
		in_ready = 1'b0;
		unique case (state_q)
			mcc_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					if (sts.load_last) begin
						pass_d  = 1'b0;
						state_d = mcc_pkg::ST_INIT;
					end
				end
			end
			mcc_pkg::ST_INIT: begin
				cmd.init = 1'b1;
				if (sts.skip) state_d = mcc_pkg::ST_NEXT;
				else if (sts.single) state_d = mcc_pkg::ST_COUNT;
				else state_d = mcc_pkg::ST_RD;
			end
			mcc_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = mcc_pkg::ST_CMP;
			end
			mcc_pkg::ST_CMP: begin
				if (sts.mismatch) state_d = mcc_pkg::ST_ADV;
				else if (sts.pair_last) state_d = mcc_pkg::ST_COUNT;
				else begin
					cmd.step = 1'b1;
					state_d  = mcc_pkg::ST_RD;
				end
			end
			mcc_pkg::ST_COUNT: begin
				cmd.inc = 1'b1;
				state_d = mcc_pkg::ST_ADV;
			end
			mcc_pkg::ST_ADV: begin
				if (sts.subset_last) state_d = mcc_pkg::ST_NEXT;
				else begin
					cmd.adv = 1'b1;
					state_d = sts.single ? mcc_pkg::ST_COUNT : mcc_pkg::ST_RD;
				end
			end
			mcc_pkg::ST_NEXT: begin
				if (!pass_q) begin
					pass_d  = 1'b1;
					state_d = mcc_pkg::ST_INIT;
				end else begin
					state_d = mcc_pkg::ST_FIN;
				end
			end
			mcc_pkg::ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = mcc_pkg::ST_LOAD;
				end
			end
			default: state_d = mcc_pkg::ST_LOAD;
		endcase
	end

endmodule

>>> rtl/mcc_dpath.sv
// ----------------------------------------------------------------------------
// mcc_dpath
// Edge memory, configuration registers, subset registers and counter.
// ----------------------------------------------------------------------------
module mcc_dpath #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_CLIQUE   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_fire,
	input  logic [mcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcc_pkg::VC_W-1:0]           cfg_data,
	input  logic                               edge_color,
	input  mcc_pkg::cmd_t                      cmd,
	output mcc_pkg::status_t                   sts,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [mcc_pkg::ENERGY_W-1:0]       energy
);

	localparam int EDGE_DEPTH = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
	localparam int AW = $clog2(EDGE_DEPTH);
	localparam int LW = $clog2(EDGE_DEPTH + 1);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int TW = $clog2(MAX_CLIQUE + 1);
	localparam int CW = $clog2(MAX_CLIQUE);

	logic [mcc_pkg::VC_W-1:0]   vc_q;
	logic [mcc_pkg::SIZE_W-1:0] red_q, blue_q;
	logic [LW-1:0]              edges_q;
	logic [mcc_pkg::ENERGY_W-1:0] total_q, out_data_q;
	logic                       out_valid_q;
	logic [VW-1:0]              members_q [MAX_CLIQUE];
	logic [VW-1:0]              members_d [MAX_CLIQUE];
	logic [CW-1:0]              pk_q, pj_q;
	logic                       rd_q;
	logic                       mem [EDGE_DEPTH];

	logic [NW-1:0]              n_eff;
	logic [TW-1:0]              t_eff;
	logic [mcc_pkg::SIZE_W-1:0] size_sel;
	logic [2*NW-1:0]            n_prod;
	logic [LW:0]                cnt_next;
	logic [VW-1:0]              a_v, b_v, piv;
	logic [2*VW-1:0]            a_prod;
	logic [AW-1:0]              rd_addr;
	logic [CW-1:0]              pos;
	logic                       found;

	// Clamp the registers into the supported ranges.
	always_comb begin
		if (vc_q < 7'd2) n_eff = NW'(2);
		else if (32'(vc_q) > 32'(MAX_VERTICES)) n_eff = NW'(MAX_VERTICES);
		else n_eff = NW'(vc_q);
		size_sel = cmd.pass ? blue_q : red_q;
		if (size_sel == '0) t_eff = TW'(1);
		else if (32'(size_sel) > 32'(MAX_CLIQUE)) t_eff = TW'(MAX_CLIQUE);
		else t_eff = TW'(size_sel);
	end

	assign n_prod   = (2*NW)'(n_eff) * ((2*NW)'(n_eff) - 1'b1);
	assign cnt_next = (LW+1)'(edges_q) + 1'b1;

	assign a_v     = members_q[pk_q];
	assign b_v     = members_q[pj_q];
	assign a_prod  = (2*VW)'(a_v) * ((2*VW)'(a_v) - 1'b1);
	assign rd_addr = AW'(a_prod >> 1) + AW'(b_v);

	// The rightmost member not yet at its upper limit is the pivot.
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int m = 0; m < MAX_CLIQUE; m++) begin
			if (32'(m) < 32'(t_eff) &&
			    32'(members_q[m]) != 32'(n_eff) - 32'(t_eff) + 32'(m)) begin
				found = 1'b1;
				pos   = CW'(m);
			end
		end
		piv = members_q[pos];
		for (int k = 0; k < MAX_CLIQUE; k++) begin
			if (32'(k) >= 32'(pos))
				members_d[k] = VW'(32'(piv) + 32'(k) - 32'(pos) + 1);
			else
				members_d[k] = members_q[k];
		end
	end

	always_comb begin
		sts.load_last   = 32'(cnt_next) >= 32'(n_prod >> 1);
		sts.skip        = 32'(t_eff) > 32'(n_eff);
		sts.single      = t_eff == TW'(1);
		sts.mismatch    = rd_q != cmd.pass;
		sts.pair_last   = (32'(pk_q) == 32'(t_eff) - 1) && (pj_q == pk_q - 1'b1);
		sts.subset_last = !found;
		sts.out_busy    = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && 32'(edges_q) < 32'(EDGE_DEPTH))
			mem[edges_q[AW-1:0]] <= edge_color;
		if (cmd.rd)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= mcc_pkg::VC_W'(64);
			red_q       <= mcc_pkg::SIZE_W'(3);
			blue_q      <= mcc_pkg::SIZE_W'(3);
			edges_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			pk_q        <= '0;
			pj_q        <= '0;
			for (int m = 0; m < MAX_CLIQUE; m++) members_q[m] <= '0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					mcc_pkg::REG_VERTEX_COUNT: vc_q <= cfg_data;
					mcc_pkg::REG_RED_SIZE:     red_q <= cfg_data[mcc_pkg::SIZE_W-1:0];
					mcc_pkg::REG_BLUE_SIZE:    blue_q <= cfg_data[mcc_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (sts.load_last) begin
					edges_q <= '0;
					total_q <= '0;
				end else begin
					edges_q <= cnt_next[LW-1:0];
				end
			end
			if (cmd.init) begin
				for (int m = 0; m < MAX_CLIQUE; m++) members_q[m] <= VW'(m);
				pk_q <= CW'(1);
				pj_q <= '0;
			end
			if (cmd.adv) begin
				for (int m = 0; m < MAX_CLIQUE; m++) members_q[m] <= members_d[m];
				pk_q <= CW'(1);
				pj_q <= '0;
			end
			if (cmd.step) begin
				if (pj_q == pk_q - 1'b1) begin
					pk_q <= pk_q + 1'b1;
					pj_q <= '0;
				end else begin
					pj_q <= pj_q + 1'b1;
				end
			end
			if (cmd.inc)
				total_q <= total_q + 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_data_q <= total_q;
	end

	assign out_valid = out_valid_q;
	assign energy    = out_data_q;

endmodule

>>> rtl/monochromatic_clique_counter.sv
// ----------------------------------------------------------------------------
// monochromatic_clique_counter
// Counts red and blue cliques of a loaded complete graph.
// ----------------------------------------------------------------------------
// The slave stream takes one edge color per transaction in lower-triangular
// order, one per cycle while loading. The transaction that completes the
// graph starts the enumeration, during which s_tready is low. Every subset of
// the red clique size is checked against red edges, then every subset of the
// blue size against blue edges, one edge read of the single-port edge memory
// per pair. A subset reads and compares its pairs in turn up to its first
// mismatch; a subset with no mismatch is counted, and then the next subset
// is formed in lexicographic order. After both passes the energy goes to the
// master output register and loading resumes; a stalled receiver holds the
// result while the next graph loads, and only the next result waits for it.
// Reset clears the counters and sets 64 vertices and clique sizes of three;
// the edge memory needs no clearing. Configuration writes are taken only
// while the block is loading, the same cycles in which s_tready is high.
module monochromatic_clique_counter #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_CLIQUE   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] edge_color
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,   // [33:0] energy
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcc_pkg::VC_W-1:0]      cfg_data
);

	mcc_pkg::cmd_t                cmd;
	mcc_pkg::status_t             sts;
	logic [mcc_pkg::ENERGY_W-1:0] energy;

	// The enumeration reads the registers, so they only change while loading.
	assign cfg_ready = s_tready;

	mcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid && s_tready),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	mcc_dpath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_CLIQUE   (MAX_CLIQUE)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_fire   (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.edge_color (s_tdata[0]),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.energy     (energy)
	);

	assign m_tdata = {6'b0, energy};

endmodule
